>>> design/arc_pkg.sv
// shared types and constants for the arc replacement engine
`default_nettype none
package arc_pkg;
    localparam int MaxPages = 64;
    localparam int PageBits = 20;
    localparam int CapBits = 7;
    localparam int OutBits = 3;

    localparam logic [OutBits-1:0] OUT_T1 = 3'd0;
    localparam logic [OutBits-1:0] OUT_T2 = 3'd1;
    localparam logic [OutBits-1:0] OUT_B1 = 3'd2;
    localparam logic [OutBits-1:0] OUT_B2 = 3'd3;
    localparam logic [OutBits-1:0] OUT_MISS = 3'd4;

    // shift command for one list row
    typedef struct packed {
        logic clear;
        logic remove;
        logic push;
    } list_cmd_t;
endpackage
`default_nettype wire

>>> design/arc_cell.sv
// one entry of a recency list: holds a page, compares and shifts toward lru
`default_nettype none
module arc_cell #(
    parameter int PAGE_W = arc_pkg::PageBits
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              is_tail,
    input  wire logic              occupied,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire logic [PAGE_W-1:0] right_page,
    input  wire logic [PAGE_W-1:0] push_page,
    input  wire logic [PAGE_W-1:0] key,
    output logic                   hit,
    output logic [PAGE_W-1:0]      page
);
    logic [PAGE_W-1:0] page_reg;

    assign page = page_reg;
    assign hit  = occupied && (page_reg == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= '0;
        end
        else if (load_en && is_tail)
        begin
            page_reg <= push_page;
        end
        else if (shift_en)
        begin
            page_reg <= right_page;
        end
    end
endmodule
`default_nettype wire

>>> design/arc_list.sv
// recency list built as a row of cells, lru at index zero
`default_nettype none
module arc_list #(
    parameter int DEPTH  = arc_pkg::MaxPages,
    parameter int PAGE_W = arc_pkg::PageBits,
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire arc_pkg::list_cmd_t cmd,
    input  wire logic              use_hit_pos,
    input  wire logic [PAGE_W-1:0] key,
    input  wire logic [PAGE_W-1:0] push_page,
    output logic                   found,
    output logic [CNT_W-1:0]       count,
    output logic [PAGE_W-1:0]      lru_page
);
    logic [CNT_W-1:0] count_reg;
    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] at_or_above;
    logic [DEPTH-1:0] shift_vec;
    logic [DEPTH-1:0] tail_vec;
    logic [PAGE_W-1:0] pages [DEPTH];
    logic [PAGE_W-1:0] rights [DEPTH];
    logic full;
    logic do_remove;
    logic [CNT_W-1:0] after_rm;

    assign count    = count_reg;
    assign lru_page = pages[0];
    assign found    = |hit_vec;
    assign full     = (count_reg == CNT_W'(DEPTH));
    // a push onto a full list drops its lru first
    assign do_remove = cmd.remove || (cmd.push && full);
    assign after_rm  = do_remove ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = (CNT_W'(i) < count_reg);
            tail_vec[i] = (CNT_W'(i) == after_rm);
            rights[i] = (i == DEPTH - 1) ? push_page : pages[(i + 1) % DEPTH];
        end
        at_or_above[0] = use_hit_pos ? hit_vec[0] : 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            at_or_above[i] = at_or_above[i-1] || (use_hit_pos && hit_vec[i]);
        end
        shift_vec = do_remove ? (at_or_above & occ) : '0;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        arc_cell #(.PAGE_W(PAGE_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .is_tail   (tail_vec[g]),
            .occupied  (occ[g]),
            .shift_en  (shift_vec[g]),
            .load_en   (cmd.push),
            .right_page(rights[g]),
            .push_page (push_page),
            .key       (key),
            .hit       (hit_vec[g]),
            .page      (pages[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= after_rm + CNT_W'(cmd.push);
        end
    end
endmodule
`default_nettype wire

>>> design/arc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module arc_div #(
    parameter int W = 7
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic [W-1:0]      quo
);
    localparam int SW = $clog2(W + 1);
    logic [W-1:0] rem_reg, quo_reg, den_reg;
    logic [SW-1:0] step_reg;
    logic busy_reg, done_reg;
    logic [W:0] trial;

    assign done  = done_reg;
    assign quo   = quo_reg;
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(W);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!trial[W])
                begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                step_reg <= step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> design/arc_page_replacement.sv
// arc policy engine: four cell-row lists, divider and step sequencer
// One reference is taken on start when busy is low. Its result is strobed on
// result_valid for one cycle after the sequencer passes look, push and done on
// hits and on misses that need no replace step, look, replace, push and done on
// misses that run replace, and look, divide, replace, ghost, push and done on
// ghost hits, where the bit-serial ratio divide sets the length. busy drops in
// the strobe cycle, so the next reference can be taken then. Writing capacity
// flushes all lists and p. The receiver cannot stall, so each result must be
// captured when strobed.
`default_nettype none
module arc_page_replacement #(
    parameter int MAX_PAGES = arc_pkg::MaxPages,
    parameter int PAGE_BITS = arc_pkg::PageBits
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [PAGE_BITS-1:0]      page_number,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [arc_pkg::CapBits-1:0] cfg_data,
    output logic                           result_valid,
    output logic [arc_pkg::OutBits-1:0]    outcome,
    output logic                           evict_valid,
    output logic [PAGE_BITS-1:0]           victim_page,
    output logic [arc_pkg::CapBits-1:0]    target_now
);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int DW = CW + 1;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DIV, S_REPL, S_GHOST, S_PUSH, S_DONE}
        state_t;

    state_t state_reg;
    logic [PAGE_BITS-1:0] key_reg, victim_reg;
    logic [arc_pkg::CapBits-1:0] cap_reg;
    logic [CW-1:0] p_reg;
    logic [arc_pkg::OutBits-1:0] out_reg;
    logic ev_reg, rv_reg, div_go;
    logic [DW-1:0] div_num, div_den, div_q;
    logic div_done;
    logic [PAGE_BITS-1:0] push_t1, push_t2, push_b1, push_b2;

    arc_pkg::list_cmd_t cmd_t1, cmd_t2, cmd_b1, cmd_b2;
    logic hpos_t1, hpos_t2, hpos_b1, hpos_b2;
    logic f_t1, f_t2, f_b1, f_b2;
    logic [CW-1:0] n_t1, n_t2, n_b1, n_b2;
    logic [PAGE_BITS-1:0] l_t1, l_t2, l_b1, l_b2;

    arc_list #(.DEPTH(MAX_PAGES), .PAGE_W(PAGE_BITS), .CNT_W(CW)) u_t1 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_t1), .use_hit_pos(hpos_t1), .key(key_reg),
        .push_page(push_t1), .found(f_t1), .count(n_t1), .lru_page(l_t1));
    arc_list #(.DEPTH(MAX_PAGES), .PAGE_W(PAGE_BITS), .CNT_W(CW)) u_t2 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_t2), .use_hit_pos(hpos_t2), .key(key_reg),
        .push_page(push_t2), .found(f_t2), .count(n_t2), .lru_page(l_t2));
    arc_list #(.DEPTH(MAX_PAGES), .PAGE_W(PAGE_BITS), .CNT_W(CW)) u_b1 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_b1), .use_hit_pos(hpos_b1), .key(key_reg),
        .push_page(push_b1), .found(f_b1), .count(n_b1), .lru_page(l_b1));
    arc_list #(.DEPTH(MAX_PAGES), .PAGE_W(PAGE_BITS), .CNT_W(CW)) u_b2 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_b2), .use_hit_pos(hpos_b2), .key(key_reg),
        .push_page(push_b2), .found(f_b2), .count(n_b2), .lru_page(l_b2));

    arc_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_q));

    // effective capacity c, clamped to 1..MAX_PAGES
    logic [CW-1:0] cap_eff;
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CW'(1);
        else if ({{(DW+8){1'b0}}, cap_reg} > (DW+8+arc_pkg::CapBits)'(MAX_PAGES))
            cap_eff = CW'(MAX_PAGES);
        else
            cap_eff = CW'(cap_reg);
    end

    logic [DW:0] l1_sum, all_sum;
    assign l1_sum  = (DW+1)'(n_t1) + (DW+1)'(n_b1);
    assign all_sum = l1_sum + (DW+1)'(n_t2) + (DW+1)'(n_b2);

    // replace choice, with a tie going to t1 on a ghost hit in b2
    logic take_t1;
    always_comb
    begin
        take_t1 = (n_t1 != '0) && ((n_t1 > p_reg) || (out_reg == arc_pkg::OUT_B2
                  && n_t1 == p_reg));
        if (!take_t1 && n_t2 == '0 && n_t1 != '0)
            take_t1 = 1'b1;
    end

    logic [DW-1:0] d_eff;
    logic [DW:0] p_up;
    assign d_eff = (div_q == '0) ? DW'(1) : div_q;
    assign p_up  = (DW+1)'(p_reg) + (DW+1)'(d_eff);

    // miss-path decisions
    logic miss_evict_t1_direct, miss_pop_b1, miss_pop_b2, miss_replace;
    always_comb
    begin
        miss_evict_t1_direct = 1'b0;
        miss_pop_b1 = 1'b0;
        miss_pop_b2 = 1'b0;
        miss_replace = 1'b0;
        if (l1_sum >= (DW+1)'(cap_eff))
        begin
            if (n_t1 < cap_eff)
            begin
                miss_pop_b1 = (n_b1 != '0);
                miss_replace = 1'b1;
            end
            else
            begin
                miss_evict_t1_direct = 1'b1;
            end
        end
        else if (all_sum >= (DW+1)'(cap_eff))
        begin
            miss_pop_b2 = (all_sum >= ((DW+1)'(cap_eff) << 1)) && (n_b2 != '0);
            miss_replace = 1'b1;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign result_valid = rv_reg;
    assign outcome = out_reg;
    assign evict_valid = ev_reg;
    assign victim_page = ev_reg ? victim_reg : '0;
    assign target_now = arc_pkg::CapBits'(p_reg);

    always_comb
    begin
        cmd_t1 = '0; cmd_t2 = '0; cmd_b1 = '0; cmd_b2 = '0;
        hpos_t1 = 1'b0; hpos_t2 = 1'b0; hpos_b1 = 1'b0; hpos_b2 = 1'b0;
        push_t1 = key_reg; push_t2 = key_reg; push_b1 = key_reg; push_b2 = key_reg;
        div_go = 1'b0;
        div_num = '0;
        div_den = '0;
        if (cfg_valid && cfg_ready)
        begin
            cmd_t1.clear = 1'b1; cmd_t2.clear = 1'b1;
            cmd_b1.clear = 1'b1; cmd_b2.clear = 1'b1;
        end
        unique case (state_reg)
            S_LOOK:
            begin
                if (f_t1)
                begin
                    cmd_t1.remove = 1'b1; hpos_t1 = 1'b1;
                end
                else if (f_t2)
                begin
                    cmd_t2.remove = 1'b1; hpos_t2 = 1'b1;
                end
                else if (f_b1)
                begin
                    div_go = 1'b1;
                    div_num = DW'(n_b2);
                    div_den = DW'(n_b1);
                end
                else if (f_b2)
                begin
                    div_go = 1'b1;
                    div_num = DW'(n_b1);
                    div_den = DW'(n_b2);
                end
                else
                begin
                    cmd_b1.remove = miss_pop_b1;
                    cmd_b2.remove = miss_pop_b2;
                    if (miss_evict_t1_direct)
                        cmd_t1.remove = 1'b1;
                end
            end
            S_REPL:
            begin
                if (take_t1)
                begin
                    cmd_t1.remove = 1'b1;
                    cmd_b1.push = 1'b1;
                    push_b1 = l_t1;
                end
                else if (n_t2 != '0)
                begin
                    cmd_t2.remove = 1'b1;
                    cmd_b2.push = 1'b1;
                    push_b2 = l_t2;
                end
            end
            S_GHOST:
            begin
                if (out_reg == arc_pkg::OUT_B1 && f_b1)
                begin
                    cmd_b1.remove = 1'b1; hpos_b1 = 1'b1;
                end
                if (out_reg == arc_pkg::OUT_B2 && f_b2)
                begin
                    cmd_b2.remove = 1'b1; hpos_b2 = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (out_reg == arc_pkg::OUT_MISS)
                    cmd_t1.push = 1'b1;
                else
                    cmd_t2.push = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= arc_pkg::CapBits'(64);
            p_reg <= '0;
            rv_reg <= 1'b0;
            ev_reg <= 1'b0;
            out_reg <= arc_pkg::OUT_T1;
            victim_reg <= '0;
            key_reg <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
                p_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        key_reg <= page_number;
                        ev_reg <= 1'b0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (f_t1)
                    begin
                        out_reg <= arc_pkg::OUT_T1;
                        state_reg <= S_PUSH;
                    end
                    else if (f_t2)
                    begin
                        out_reg <= arc_pkg::OUT_T2;
                        state_reg <= S_PUSH;
                    end
                    else if (f_b1)
                    begin
                        out_reg <= arc_pkg::OUT_B1;
                        state_reg <= S_DIV;
                    end
                    else if (f_b2)
                    begin
                        out_reg <= arc_pkg::OUT_B2;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        out_reg <= arc_pkg::OUT_MISS;
                        if (miss_evict_t1_direct)
                        begin
                            ev_reg <= 1'b1;
                            victim_reg <= l_t1;
                            state_reg <= S_PUSH;
                        end
                        else if (miss_replace)
                            state_reg <= S_REPL;
                        else
                            state_reg <= S_PUSH;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (out_reg == arc_pkg::OUT_B1)
                            p_reg <= (p_up > (DW+1)'(cap_eff)) ? cap_eff : CW'(p_up);
                        else
                            p_reg <= ((DW+1)'(p_reg) > (DW+1)'(d_eff))
                                ? CW'((DW+1)'(p_reg) - (DW+1)'(d_eff)) : '0;
                        state_reg <= S_REPL;
                    end
                end
                S_REPL:
                begin
                    if (take_t1)
                    begin
                        ev_reg <= 1'b1;
                        victim_reg <= l_t1;
                    end
                    else if (n_t2 != '0)
                    begin
                        ev_reg <= 1'b1;
                        victim_reg <= l_t2;
                    end
                    state_reg <= (out_reg == arc_pkg::OUT_MISS) ? S_PUSH : S_GHOST;
                end
                S_GHOST:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rv_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("config taken while busy");
    a_rv_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_DONE))
        else $error("result strobe without completion");
    a_p_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= CW'(MAX_PAGES))
        else $error("target beyond capacity");
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !evict_valid) |-> (victim_page == '0))
        else $error("victim without eviction");
endmodule
`default_nettype wire

>>> tb/arc_checker.sv
// transfer monitor, arc policy predictor and result comparator
`default_nettype none
module arc_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic [arc_pkg::PageBits-1:0] page_number,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [arc_pkg::CapBits-1:0]  cfg_data,
    input  wire logic                         result_valid,
    input  wire logic [arc_pkg::OutBits-1:0]  outcome,
    input  wire logic                         evict_valid,
    input  wire logic [arc_pkg::PageBits-1:0] victim_page,
    input  wire logic [arc_pkg::CapBits-1:0]  target_now,
    output int                                pending,
    output int                                fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {LIST_T1 = 0, LIST_T2 = 1, LIST_B1 = 2, LIST_B2 = 3} list_id_t;

    typedef struct {
        logic [arc_pkg::OutBits-1:0]  kind;
        logic                         evicted;
        logic [arc_pkg::PageBits-1:0] victim;
        logic [arc_pkg::CapBits-1:0]  target;
    } arc_result_t;

    logic [arc_pkg::PageBits-1:0] pages [4][arc_pkg::MaxPages];
    int                           len [4];
    int                           target_p;
    int                           cap_reg;
    arc_result_t                  expected_q [$];

    function automatic int find_page(list_id_t l, logic [arc_pkg::PageBits-1:0] pg);
        for (int i = 0; i < len[l]; i++)
            if (pages[l][i] == pg) return i;
        return -1;
    endfunction

    function automatic void drop_at(list_id_t l, int i);
        if (i < 0 || i >= len[l]) return;
        for (int k = i; k < len[l] - 1; k++) pages[l][k] = pages[l][k+1];
        len[l]--;
    endfunction

    function automatic logic [arc_pkg::PageBits-1:0] take_lru(list_id_t l);
        logic [arc_pkg::PageBits-1:0] pg;
        pg = pages[l][0];
        drop_at(l, 0);
        return pg;
    endfunction

    function automatic void put_mru(list_id_t l, logic [arc_pkg::PageBits-1:0] pg);
        if (len[l] >= arc_pkg::MaxPages) drop_at(l, 0);
        pages[l][len[l]] = pg;
        len[l]++;
    endfunction

    function automatic void flush_lists();
        for (int l = 0; l < 4; l++) len[l] = 0;
        target_p = 0;
    endfunction

    // evict one resident page into its ghost list
    function automatic logic evict_one(logic from_b2,
                                       output logic [arc_pkg::PageBits-1:0] victim);
        logic use_t1;
        int   t1;
        t1 = len[LIST_T1];
        use_t1 = t1 > 0 && (t1 > target_p || (from_b2 && t1 == target_p));
        if (!use_t1 && len[LIST_T2] == 0 && t1 > 0) use_t1 = 1'b1;
        victim = '0;
        if (use_t1) begin
            victim = take_lru(LIST_T1);
            put_mru(LIST_B1, victim);
            return 1'b1;
        end
        if (len[LIST_T2] > 0) begin
            victim = take_lru(LIST_T2);
            put_mru(LIST_B2, victim);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic arc_result_t arc_reference(logic [arc_pkg::PageBits-1:0] pg);
        arc_result_t r;
        int          c, d, idx, l1, all;
        logic [arc_pkg::PageBits-1:0] v;
        c = cap_reg < 1 ? 1 : (cap_reg > arc_pkg::MaxPages ? arc_pkg::MaxPages : cap_reg);
        v = '0;
        r.evicted = 1'b0;
        if ((idx = find_page(LIST_T1, pg)) >= 0) begin
            r.kind = arc_pkg::OUT_T1;
            drop_at(LIST_T1, idx);
            put_mru(LIST_T2, pg);
        end else if ((idx = find_page(LIST_T2, pg)) >= 0) begin
            r.kind = arc_pkg::OUT_T2;
            drop_at(LIST_T2, idx);
            put_mru(LIST_T2, pg);
        end else if (find_page(LIST_B1, pg) >= 0) begin
            r.kind = arc_pkg::OUT_B1;
            d = len[LIST_B2] / len[LIST_B1];
            if (d < 1) d = 1;
            target_p = (target_p + d > c) ? c : target_p + d;
            r.evicted = evict_one(1'b0, v);
            drop_at(LIST_B1, find_page(LIST_B1, pg));
            put_mru(LIST_T2, pg);
        end else if (find_page(LIST_B2, pg) >= 0) begin
            r.kind = arc_pkg::OUT_B2;
            d = len[LIST_B1] / len[LIST_B2];
            if (d < 1) d = 1;
            target_p = (target_p > d) ? target_p - d : 0;
            r.evicted = evict_one(1'b1, v);
            drop_at(LIST_B2, find_page(LIST_B2, pg));
            put_mru(LIST_T2, pg);
        end else begin
            r.kind = arc_pkg::OUT_MISS;
            l1 = len[LIST_T1] + len[LIST_B1];
            all = l1 + len[LIST_T2] + len[LIST_B2];
            if (l1 >= c) begin
                if (len[LIST_T1] < c) begin
                    if (len[LIST_B1] > 0) void'(take_lru(LIST_B1));
                    r.evicted = evict_one(1'b0, v);
                end else begin
                    v = take_lru(LIST_T1);
                    r.evicted = 1'b1;
                end
            end else if (all >= c) begin
                if (all >= 2 * c && len[LIST_B2] > 0) void'(take_lru(LIST_B2));
                r.evicted = evict_one(1'b0, v);
            end
            put_mru(LIST_T1, pg);
        end
        r.victim = r.evicted ? v : '0;
        r.target = target_p[arc_pkg::CapBits-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fails++;
    endtask

    initial begin
        fails = 0;
        pending = 0;
        cap_reg = arc_pkg::MaxPages;
        flush_lists();
    end

    always @(posedge clk or negedge rst_n) begin
        arc_result_t want;
        if (!rst_n) begin
            cap_reg = arc_pkg::MaxPages;
            flush_lists();
            expected_q.delete();
            pending <= 0;
        end else begin
            if (result_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (outcome !== want.kind) report_mismatch("outcome", outcome, want.kind);
                    if (evict_valid !== want.evicted)
                        report_mismatch("evict_valid", evict_valid, want.evicted);
                    if (victim_page !== want.victim)
                        report_mismatch("victim_page", victim_page, want.victim);
                    if (target_now !== want.target)
                        report_mismatch("target_now", target_now, want.target);
                end
            end
            if (cfg_valid && cfg_ready) begin
                cap_reg = cfg_data;
                flush_lists();
            end
            if (start && !busy) expected_q.push_back(arc_reference(page_number));
            pending <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_arc_page_replacement.sv
// stimulus and verdict for the arc replacement engine
`default_nettype none
module tb_arc_page_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 600000;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [arc_pkg::PageBits-1:0] page_number;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [arc_pkg::CapBits-1:0]  cfg_data;
    logic                         result_valid;
    logic [arc_pkg::OutBits-1:0]  outcome;
    logic                         evict_valid;
    logic [arc_pkg::PageBits-1:0] victim_page;
    logic [arc_pkg::CapBits-1:0]  target_now;
    int                           pending;
    int                           fails;
    int                           cycles;
    logic                         no_gaps;
    logic [arc_pkg::PageBits-1:0] pool [200];

    arc_page_replacement dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .page_number(page_number),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .outcome(outcome), .evict_valid(evict_valid),
        .victim_page(victim_page), .target_now(target_now)
    );

    arc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .page_number(page_number),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .outcome(outcome), .evict_valid(evict_valid),
        .victim_page(victim_page), .target_now(target_now),
        .pending(pending), .fails(fails)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_arc_page_replacement NOT OK");
            $finish;
        end
    end

    task automatic reference_page(logic [arc_pkg::PageBits-1:0] pg);
        if (!no_gaps && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        page_number <= pg;
        do @(posedge clk); while (busy);
    endtask

    // settle: nothing outstanding and no ghost-hit divide still running
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_capacity(logic [arc_pkg::CapBits-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [arc_pkg::CapBits-1:0] caps [10] = '{7'd1, 7'd2, 7'd3, 7'd8, 7'd64,
                                                   7'd0, 7'd127, 7'd5, 7'd16, 7'd64};
        int c, psize;
        cycles = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        page_number = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: extremes of the page field, t1 hit then t2 hit
        reference_page('0);
        reference_page('1);
        reference_page('0);
        reference_page('0);
        reference_page('1);

        // one frame: misses evict, then ghost hits in b2
        write_capacity(7'd1);
        reference_page(20'h00010);
        reference_page(20'h00020);
        reference_page(20'h00010);
        reference_page(20'h00010);
        reference_page(20'h00030);
        reference_page(20'h00010);
        reference_page(20'h00020);
        reference_page(20'h00030);
        reference_page(20'h00040);
        reference_page(20'h00010);

        foreach (caps[ph]) begin
            write_capacity(ph == 9 ? 7'($urandom_range(1, 127)) : caps[ph]);
            c = caps[ph] < 1 ? 1 : (caps[ph] > arc_pkg::MaxPages ? arc_pkg::MaxPages
                                                                  : caps[ph]);
            psize = 2 * c + $urandom_range(1, c + 4);
            if (psize > 200) psize = 200;
            foreach (pool[i]) pool[i] = 20'($urandom);
            if (ph == 4) begin
                reference_page(20'h12345);
                drain();
            end
            for (int n = 0; n < 125; n++) begin
                no_gaps = (ph == 2);
                if ($urandom_range(99) < 12) reference_page(20'($urandom));
                else if ($urandom_range(1)) reference_page(pool[$urandom_range(psize - 1)]);
                else reference_page(pool[$urandom_range((psize + 1) / 2 - 1)]);
            end
        end

        drain();
        if (fails == 0)
            $display("tb_arc_page_replacement OK");
        else
            $display("tb_arc_page_replacement NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
